// ===== hdl/blink_tween_shaper_macros.svh =====
// ---------------------------------------------------------------------------
// Blink tween shaper assertion macros
// Shared concurrent assertion forms clocked on aclk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef BLINK_TWEEN_SHAPER_MACROS_SVH
`define BLINK_TWEEN_SHAPER_MACROS_SVH

// same-cycle implication
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
// ---------------------------------------------------------------------------
// Blink tween shaper package
// Types, register map, sequencer states and Q1.15 constants.
// ---------------------------------------------------------------------------
package bts_pkg;

    localparam int ONE_Q15        = 32768;
    localparam int HALF_Q15       = 16384;
    localparam int VEL_SMOOTH_DEF = 22938;
    localparam int VEL_MAX        = 131071;
    localparam int VEL_MIN        = -131072;
    localparam int CLOSE_OV_MIN   = 26215;   // p > 0.8
    localparam int OPEN_OV_MAX    = 9830;    // q < 0.3
    localparam int OPEN_OV_SPAN   = 98304;
    localparam int OPEN_OV_HALF   = 49152;
    localparam int DIV3_MAGIC     = 174763;
    localparam int DIV3_SHIFT     = 19;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int MUL_W  = 19;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [15:0] RST_CLOSE_THR = 16'd6554;
    localparam logic [17:0] RST_VEL_THR   = 18'h3F333;   // -3277
    localparam logic [15:0] RST_REOPEN    = 16'd16384;
    localparam logic [7:0]  RST_MIN_FR    = 8'd3;
    localparam logic [7:0]  RST_MAX_FR    = 8'd30;
    localparam logic [15:0] RST_CLOSE_STP = 16'd3277;
    localparam logic [15:0] RST_OPEN_STP  = 16'd1638;
    localparam logic [15:0] RST_OVERSHOOT = 16'd1638;

    typedef struct packed {
        logic [15:0]        close_threshold;
        logic signed [17:0] velocity_threshold;
        logic [15:0]        reopen_threshold;
        logic [7:0]         min_blink_frames;
        logic [7:0]         max_blink_frames;
        logic [15:0]        close_step;
        logic [15:0]        open_step;
        logic [15:0]        overshoot_amount;
    } bts_cfg_t;

    typedef enum logic [2:0] {
        REG_CLOSE_THR  = 3'd0,
        REG_VEL_THR    = 3'd1,
        REG_REOPEN_THR = 3'd2,
        REG_MIN_FRAMES = 3'd3,
        REG_MAX_FRAMES = 3'd4,
        REG_CLOSE_STEP = 3'd5,
        REG_OPEN_STEP  = 3'd6,
        REG_OVERSHOOT  = 3'd7
    } bts_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEL_A,
        ST_VEL_B,
        ST_VEL_C,
        ST_PHASE,
        ST_FRAC_MUL,
        ST_FRAC_SAT,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_BLEND_C,
        ST_OVER_A,
        ST_OVER_B,
        ST_PUSH
    } bts_state_t;

    // floor((x + 0.5) / 1.0) in Q1.15
    function automatic logic signed [22:0] round_q15(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] y;
        y = x + PROD_W'(HALF_Q15);
        return y[PROD_W-1:15];
    endfunction

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

// ===== hdl/bts_regs.sv =====
// ---------------------------------------------------------------------------
// Blink tween shaper register file
// APB-style configuration registers with reset defaults and read-back.
// ---------------------------------------------------------------------------
module bts_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bts_pkg::ADDR_W-1:0] paddr,
    input  logic [bts_pkg::DATA_W-1:0] pwdata,
    output logic [bts_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bts_pkg::bts_cfg_t          cfg
);
    import bts_pkg::*;

    bts_cfg_t cfg_reg;
    bts_cfg_t cfg_next;
    bts_reg_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = bts_reg_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_CLOSE_THR:  cfg_next.close_threshold    = pwdata[15:0];
                REG_VEL_THR:    cfg_next.velocity_threshold = pwdata[17:0];
                REG_REOPEN_THR: cfg_next.reopen_threshold   = pwdata[15:0];
                REG_MIN_FRAMES: cfg_next.min_blink_frames   = pwdata[7:0];
                REG_MAX_FRAMES: cfg_next.max_blink_frames   = pwdata[7:0];
                REG_CLOSE_STEP: cfg_next.close_step         = pwdata[15:0];
                REG_OPEN_STEP:  cfg_next.open_step          = pwdata[15:0];
                REG_OVERSHOOT:  cfg_next.overshoot_amount   = pwdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.close_threshold    <= RST_CLOSE_THR;
            cfg_reg.velocity_threshold <= RST_VEL_THR;
            cfg_reg.reopen_threshold   <= RST_REOPEN;
            cfg_reg.min_blink_frames   <= RST_MIN_FR;
            cfg_reg.max_blink_frames   <= RST_MAX_FR;
            cfg_reg.close_step         <= RST_CLOSE_STP;
            cfg_reg.open_step          <= RST_OPEN_STP;
            cfg_reg.overshoot_amount   <= RST_OVERSHOOT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (idx)
            REG_CLOSE_THR:  prdata = {16'd0, cfg_reg.close_threshold};
            REG_VEL_THR:    prdata = {{14{cfg_reg.velocity_threshold[17]}},
                                      cfg_reg.velocity_threshold};
            REG_REOPEN_THR: prdata = {16'd0, cfg_reg.reopen_threshold};
            REG_MIN_FRAMES: prdata = {24'd0, cfg_reg.min_blink_frames};
            REG_MAX_FRAMES: prdata = {24'd0, cfg_reg.max_blink_frames};
            REG_CLOSE_STEP: prdata = {16'd0, cfg_reg.close_step};
            REG_OPEN_STEP:  prdata = {16'd0, cfg_reg.open_step};
            REG_OVERSHOOT:  prdata = {16'd0, cfg_reg.overshoot_amount};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/blink_tween_shaper.sv =====
// Outside a blink the frac, blend and overshoot states are skipped; a new input beat
// is taken only in idle, once the previous result has been pushed out.
// Every product goes through one shared 19x19 multiplier, one product per cycle.
// Reset (aresetn low, synchronous): phase, velocity and history clear,
// registers return to defaults, no result is pending.
// ---------------------------------------------------------------------------
// Blink tween shaper
// Smooths eye-openness velocity, tracks the blink phase and blends the
// output toward closed and back, with overshoot near the phase ends.
// ---------------------------------------------------------------------------
`include "blink_tween_shaper_macros.svh"

module blink_tween_shaper #(
    parameter int unsigned VELOCITY_SMOOTH = bts_pkg::VEL_SMOOTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // [15:0] openness_in
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // [15:0] openness_out
    output logic [1:0]                 m_tuser,   // [0] closing, [1] recovering
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bts_pkg::ADDR_W-1:0] paddr,
    input  logic [bts_pkg::DATA_W-1:0] pwdata,
    output logic [bts_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bts_pkg::*;

    localparam logic signed [MUL_W-1:0] K_OP  = MUL_W'(VELOCITY_SMOOTH);
    localparam logic signed [MUL_W-1:0] KC_OP = MUL_W'(ONE_Q15 - int'(VELOCITY_SMOOTH));

    bts_cfg_t   cfg;
    bts_state_t state_reg, state_next;

    logic [15:0]              s_reg, prev_reg, pre_reg, tgt_reg, frac_reg, res_reg;
    logic signed [17:0]       vel_reg;
    logic                     cl_reg, rc_reg;
    logic [7:0]               cnt_reg;
    logic signed [PROD_W-1:0] mul_reg, acc_reg;
    logic signed [22:0]       t_reg;
    logic [18:0]              ov_reg;
    logic                     m_valid_reg;
    logic [15:0]              m_data_reg;
    logic [1:0]               m_user_reg;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic                     mul_en;
    logic                     push_ok;
    logic [15:0]              s_sat;
    logic signed [16:0]       diff;
    logic [16:0]              comp_w;
    logic [18:0]              span_w;
    logic [18:0]              div_y;
    logic signed [PROD_W-1:0] vel_sum, ov5;
    logic signed [22:0]       vel_rnd, ov_rnd, blend_rnd;
    logic signed [17:0]       vel_sat;
    logic                     ov_flag;
    logic signed [22:0]       fin;
    logic [15:0]              fin_clamp;

    logic                     ph_start, ph_cl, ph_rc, ph_end;
    logic [15:0]              ph_pre, ph_tgt;
    logic [7:0]               ph_cnt, ph_c2;
    logic [19:0]              s10, p9;

    bts_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign push_ok  = !m_valid_reg || m_tready;
    assign s_sat    = (s_tdata > 16'(ONE_Q15)) ? 16'(ONE_Q15) : s_tdata;
    assign diff     = $signed({1'b0, s_reg}) - $signed({1'b0, prev_reg});
    assign comp_w   = 17'(ONE_Q15) - {1'b0, frac_reg};
    assign span_w   = 19'(OPEN_OV_SPAN) - (({3'd0, frac_reg} << 3) + ({3'd0, frac_reg} << 1));
    assign ov_flag  = cl_reg ? (frac_reg >= 16'(CLOSE_OV_MIN))
                             : (frac_reg <= 16'(OPEN_OV_MAX));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_VEL_A;
            ST_VEL_A:    state_next = ST_VEL_B;
            ST_VEL_B:    state_next = ST_VEL_C;
            ST_VEL_C:    state_next = ST_PHASE;
            ST_PHASE:    state_next = (ph_cl || ph_rc) ? ST_FRAC_MUL : ST_PUSH;
            ST_FRAC_MUL: state_next = ST_FRAC_SAT;
            ST_FRAC_SAT: state_next = ST_BLEND_A;
            ST_BLEND_A:  state_next = ST_BLEND_B;
            ST_BLEND_B:  state_next = ST_BLEND_C;
            ST_BLEND_C:  state_next = ST_OVER_A;
            ST_OVER_A:   state_next = ST_OVER_B;
            ST_OVER_B:   state_next = ST_PUSH;
            ST_PUSH:     if (push_ok) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = state_reg inside {ST_VEL_A, ST_VEL_B, ST_FRAC_MUL, ST_BLEND_A,
                                   ST_BLEND_B, ST_BLEND_C, ST_OVER_A};
        case (state_reg)
            ST_VEL_A: begin
                mul_a = MUL_W'(vel_reg);
                mul_b = K_OP;
            end
            ST_VEL_B: begin
                mul_a = MUL_W'(diff);
                mul_b = KC_OP;
            end
            ST_FRAC_MUL: begin
                mul_a = $signed({11'd0, cnt_reg});
                mul_b = $signed({3'd0, cl_reg ? cfg.close_step : cfg.open_step});
            end
            ST_BLEND_A: begin
                mul_a = $signed({3'd0, cl_reg ? pre_reg : tgt_reg});
                mul_b = $signed({2'd0, comp_w});
            end
            ST_BLEND_B: begin
                mul_a = $signed({3'd0, cl_reg ? tgt_reg : s_reg});
                mul_b = $signed({3'd0, frac_reg});
            end
            ST_BLEND_C: begin
                mul_a = $signed({3'd0, cfg.overshoot_amount});
                mul_b = cl_reg ? $signed({2'd0, comp_w}) : $signed(span_w);
            end
            ST_OVER_A: begin
                mul_a = $signed(div_y);
                mul_b = MUL_W'(DIV3_MAGIC);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // velocity update
    always_comb begin
        vel_sum = acc_reg + mul_reg;
        vel_rnd = round_q15(vel_sum);
        if (vel_rnd > 23'(VEL_MAX)) begin
            vel_sat = 18'(VEL_MAX);
        end else if (vel_rnd < 23'(VEL_MIN)) begin
            vel_sat = 18'(VEL_MIN);
        end else begin
            vel_sat = vel_rnd[17:0];
        end
    end

    // phase update
    always_comb begin
        ph_start = !cl_reg && !rc_reg &&
                   ((s_reg < cfg.close_threshold) ||
                    ($signed(vel_reg) < $signed(cfg.velocity_threshold)));
        ph_cl  = cl_reg || ph_start;
        ph_rc  = rc_reg;
        ph_pre = ph_start ? prev_reg : pre_reg;
        ph_tgt = ph_start ? 16'd0 : tgt_reg;
        ph_cnt = ph_start ? 8'd0 : cnt_reg;
        ph_c2  = sat_inc(ph_cnt);
        ph_end = ((ph_c2 > cfg.min_blink_frames) && (s_reg > cfg.reopen_threshold)) ||
                 (ph_c2 > cfg.max_blink_frames);
        if (ph_cl) begin
            ph_cnt = ph_c2;
            if (ph_end) begin
                ph_cl  = 1'b0;
                ph_rc  = 1'b1;
                ph_tgt = ph_pre;
                ph_cnt = 8'd0;
            end
        end
        s10 = ({4'd0, s_reg} << 3) + ({4'd0, s_reg} << 1);
        p9  = ({4'd0, ph_pre} << 3) + {4'd0, ph_pre};
        if (ph_rc) begin
            ph_cnt = sat_inc(ph_cnt);
            if (s10 > p9) begin
                ph_rc  = 1'b0;
                ph_cnt = 8'd0;
            end
        end
    end

    // overshoot and final clamp
    always_comb begin
        blend_rnd = round_q15(acc_reg);
        ov5       = (mul_reg <<< 2) + mul_reg;
        ov_rnd    = round_q15(ov5);
        div_y     = 19'((mul_reg + PROD_W'(OPEN_OV_HALF)) >>> 15);
        fin       = t_reg;
        if (cl_reg) begin
            if (ov_flag) begin
                fin = t_reg - $signed({4'd0, ov_reg});
                if (fin < $signed({7'd0, tgt_reg})) begin
                    fin = $signed({7'd0, tgt_reg});
                end
            end
        end else if (ov_flag) begin
            fin = t_reg + $signed({6'd0, mul_reg[DIV3_SHIFT+16:DIV3_SHIFT]});
        end
        if (fin < 23'sd0) begin
            fin_clamp = 16'd0;
        end else if (fin > 23'(ONE_Q15)) begin
            fin_clamp = 16'(ONE_Q15);
        end else begin
            fin_clamp = fin[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_reg    <= '0;
            vel_reg     <= '0;
            cl_reg      <= 1'b0;
            rc_reg      <= 1'b0;
            pre_reg     <= '0;
            tgt_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_VEL_C) begin
                vel_reg <= vel_sat;
            end
            if (state_reg == ST_PHASE) begin
                prev_reg <= s_reg;
                cl_reg   <= ph_cl;
                rc_reg   <= ph_rc;
                pre_reg  <= ph_pre;
                tgt_reg  <= ph_tgt;
                cnt_reg  <= ph_cnt;
            end
            if (state_reg == ST_PUSH && push_ok) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            s_reg <= s_sat;
        end
        if (mul_en) begin
            mul_reg <= mul_a * mul_b;
        end
        case (state_reg)
            ST_VEL_B, ST_BLEND_B: acc_reg <= mul_reg;
            ST_BLEND_C:           acc_reg <= acc_reg + mul_reg;
            default:              acc_reg <= acc_reg;
        endcase
        if (state_reg == ST_FRAC_SAT) begin
            frac_reg <= (mul_reg > PROD_W'(ONE_Q15)) ? 16'(ONE_Q15) : mul_reg[15:0];
        end
        if (state_reg == ST_OVER_A) begin
            t_reg  <= blend_rnd;
            ov_reg <= ov_rnd[18:0];
        end
        if (state_reg == ST_PHASE) begin
            res_reg <= s_reg;
        end else if (state_reg == ST_OVER_B) begin
            res_reg <= fin_clamp;
        end
        if (state_reg == ST_PUSH && push_ok) begin
            m_data_reg <= res_reg;
            m_user_reg <= {rc_reg, cl_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    `BTS_ASSERT_IMP(a_phase_excl, 1'b1, !(cl_reg && rc_reg), "closing and recovering both set")
    `BTS_ASSERT_IMP(a_close_tgt, cl_reg, tgt_reg == 16'd0, "closing target not zero")
    `BTS_ASSERT_IMP(a_idle_count, !cl_reg && !rc_reg, cnt_reg == 8'd0, "frame count left over")
    `BTS_ASSERT_IMP(a_out_range, m_tvalid, m_tdata <= 16'(ONE_Q15), "result above one")
    `BTS_ASSERT_NXT(a_start_seq, s_tvalid && s_tready, state_reg == ST_VEL_A, "beat not taken")

endmodule

// ===== bench/tb_blink_tween_shaper.sv =====
// ---------------------------------------------------------------------------
// Blink tween shaper testbench
// Sends openness beats on the stream input and predicts every shaped beat
// from an in-bench copy of the blink phase, velocity and blend logic.
// Results are checked field by field across register settings, with
// sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module tb_blink_tween_shaper;
    import bts_pkg::*;

    localparam int SMOOTH       = VEL_SMOOTH_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [15:0] openness;
        logic        closing;
        logic        recovering;
    } shaped_beat_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [15:0]         s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [DATA_W-1:0]   pwdata   = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bts_cfg_t     shaper_cfg;
    int           prev_level;
    longint       eye_velocity;
    bit           in_closing;
    bit           in_recovery;
    int           pre_level;
    int           target_level;
    int           frame_count;

    shaped_beat_t pending_shapes[$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    blink_tween_shaper i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic longint q15_round(input longint x);
        return (x + 16384) >>> 15;
    endfunction

    function automatic void load_defaults();
        shaper_cfg.close_threshold    = RST_CLOSE_THR;
        shaper_cfg.velocity_threshold = RST_VEL_THR;
        shaper_cfg.reopen_threshold   = RST_REOPEN;
        shaper_cfg.min_blink_frames   = RST_MIN_FR;
        shaper_cfg.max_blink_frames   = RST_MAX_FR;
        shaper_cfg.close_step         = RST_CLOSE_STP;
        shaper_cfg.open_step          = RST_OPEN_STP;
        shaper_cfg.overshoot_amount   = RST_OVERSHOOT;
        prev_level   = 0;
        eye_velocity = 0;
        in_closing   = 1'b0;
        in_recovery  = 1'b0;
        pre_level    = 0;
        target_level = 0;
        frame_count  = 0;
    endfunction

    function automatic shaped_beat_t shape_frame(input logic [15:0] raw);
        longint       s;
        longint       acc;
        longint       p;
        longint       q;
        longint       t;
        longint       ov;
        shaped_beat_t r;
        s = (raw > 16'd32768) ? 32768 : longint'(raw);

        acc = eye_velocity * SMOOTH + (s - prev_level) * (ONE_Q15 - SMOOTH);
        eye_velocity = q15_round(acc);
        if (eye_velocity > VEL_MAX) eye_velocity = VEL_MAX;
        if (eye_velocity < VEL_MIN) eye_velocity = VEL_MIN;

        if (!in_closing && !in_recovery &&
            (s < longint'(shaper_cfg.close_threshold) ||
             eye_velocity < longint'(shaper_cfg.velocity_threshold))) begin
            in_closing   = 1'b1;
            frame_count  = 0;
            pre_level    = prev_level;
            target_level = 0;
        end
        prev_level = int'(s);

        if (in_closing) begin
            if (frame_count < 255) frame_count++;
            if ((frame_count > int'(shaper_cfg.min_blink_frames) &&
                 s > longint'(shaper_cfg.reopen_threshold)) ||
                frame_count > int'(shaper_cfg.max_blink_frames)) begin
                in_closing   = 1'b0;
                in_recovery  = 1'b1;
                target_level = pre_level;
                frame_count  = 0;
            end
        end

        if (in_recovery) begin
            if (frame_count < 255) frame_count++;
            if (s * 10 > longint'(pre_level) * 9) begin
                in_recovery = 1'b0;
                frame_count = 0;
            end
        end

        if (in_closing) begin
            p = longint'(frame_count) * longint'(shaper_cfg.close_step);
            if (p > ONE_Q15) p = ONE_Q15;
            t = q15_round(longint'(pre_level) * (ONE_Q15 - p) + longint'(target_level) * p);
            if (p * 5 > 131072) begin
                ov = q15_round(longint'(shaper_cfg.overshoot_amount) * (ONE_Q15 - p) * 5);
                t  = t - ov;
                if (t < target_level) t = target_level;
            end
        end else if (in_recovery) begin
            q = longint'(frame_count) * longint'(shaper_cfg.open_step);
            if (q > ONE_Q15) q = ONE_Q15;
            t = q15_round(longint'(target_level) * (ONE_Q15 - q) + s * q);
            if (q * 10 < OPEN_OV_SPAN) begin
                t = t + (longint'(shaper_cfg.overshoot_amount) * (OPEN_OV_SPAN - q * 10)
                         + OPEN_OV_HALF) / OPEN_OV_SPAN;
                if (t > ONE_Q15) t = ONE_Q15;
            end
        end else begin
            t = s;
        end

        if (t < 0) t = 0;
        if (t > ONE_Q15) t = ONE_Q15;
        r.openness   = 16'(t);
        r.closing    = in_closing;
        r.recovering = in_recovery;
        return r;
    endfunction

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        shaped_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_shapes.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got openness %0d tuser %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_shapes.pop_front();
                if (m_tdata !== want.openness) begin
                    $display("%0t: openness expected %0d, got %0d",
                             $time, want.openness, m_tdata);
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.closing) begin
                    $display("%0t: closing expected %0d, got %0d",
                             $time, want.closing, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tuser[1] !== want.recovering) begin
                    $display("%0t: recovering expected %0d, got %0d",
                             $time, want.recovering, m_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic feed_openness(input logic [15:0] level);
        s_tvalid <= 1'b1;
        s_tdata  <= level;
        do @(posedge aclk); while (!s_tready);
        pending_shapes.insert(pending_shapes.size(), shape_frame(level));
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_shapes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input bts_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_CLOSE_THR:  shaper_cfg.close_threshold    = value[15:0];
            REG_VEL_THR:    shaper_cfg.velocity_threshold = value[17:0];
            REG_REOPEN_THR: shaper_cfg.reopen_threshold   = value[15:0];
            REG_MIN_FRAMES: shaper_cfg.min_blink_frames   = value[7:0];
            REG_MAX_FRAMES: shaper_cfg.max_blink_frames   = value[7:0];
            REG_CLOSE_STEP: shaper_cfg.close_step         = value[15:0];
            REG_OPEN_STEP:  shaper_cfg.open_step          = value[15:0];
            REG_OVERSHOOT:  shaper_cfg.overshoot_amount   = value[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all(input int close_thr, input int vel_thr, input int reopen,
                             input int min_fr, input int max_fr, input int close_stp,
                             input int open_stp, input int overshoot);
        write_register(REG_CLOSE_THR,  32'(close_thr));
        write_register(REG_VEL_THR,    32'(vel_thr));
        write_register(REG_REOPEN_THR, 32'(reopen));
        write_register(REG_MIN_FRAMES, 32'(min_fr));
        write_register(REG_MAX_FRAMES, 32'(max_fr));
        write_register(REG_CLOSE_STEP, 32'(close_stp));
        write_register(REG_OPEN_STEP,  32'(open_stp));
        write_register(REG_OVERSHOOT,  32'(overshoot));
    endtask

    function automatic int pick(input int lo, input int hi, input int typ_lo, input int typ_hi);
        int r;
        r = $urandom_range(15);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(typ_hi, typ_lo);
    endfunction

    task automatic randomise_settings();
        int r;
        int vel_thr;
        r = $urandom_range(15);
        vel_thr = (r == 0) ? VEL_MIN : (r == 1) ? VEL_MAX : -int'($urandom_range(8000, 500));
        write_all(pick(0, 65535, 2000, 10000), vel_thr, pick(0, 65535, 10000, 24000),
                  pick(0, 255, 1, 6), pick(0, 255, 8, 30), pick(0, 65535, 2000, 12000),
                  pick(0, 65535, 1000, 8000), pick(0, 65535, 0, 4000));
    endtask

    task automatic send_blink_burst(inout int sent);
        int level;
        int closed_frames;
        int ramp_frames;
        int peak;
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(4, 1)) begin
                feed_openness(16'($urandom));
                sent++;
            end
        end else begin
            level = $urandom_range(32768, 18000);
            repeat ($urandom_range(5, 1)) begin
                feed_openness(16'(level - int'($urandom_range(500))));
                sent++;
            end
            if ($urandom_range(1) == 0)
                feed_openness(16'($urandom_range(4000)));
            else
                feed_openness(16'(level / 2));
            sent++;
            closed_frames = ($urandom_range(7) == 0) ? int'(shaper_cfg.max_blink_frames) + 3
                                                     : int'($urandom_range(12));
            if (closed_frames > 40) closed_frames = 40;
            repeat (closed_frames) begin
                feed_openness(16'($urandom_range(3000)));
                sent++;
            end
            ramp_frames = $urandom_range(8, 2);
            peak = ($urandom_range(3) == 0) ? (level * 7) / 10 : level;
            for (int k = 1; k <= ramp_frames; k++) begin
                feed_openness(16'((peak * k) / ramp_frames));
                sent++;
            end
        end
    endtask

    task automatic test_default_blinks();
        feed_openness(16'd32768);
        feed_openness(16'd32768);
        feed_openness(16'hFFFF);
        feed_openness(16'd32768);
        feed_openness(16'd12000);
        feed_openness(16'd0);
        feed_openness(16'd0);
        feed_openness(16'd0);
        feed_openness(16'd20000);
        feed_openness(16'd25000);
        feed_openness(16'd32769);
        feed_openness(16'd0);
        feed_openness(16'd1000);
        feed_openness(16'd32768);
        settle_block();
    endtask

    task automatic test_register_extremes();
        write_all(0, 0, 0, 0, 0, 0, 0, 0);
        feed_openness(16'd32768);
        feed_openness(16'd0);
        feed_openness(16'd0);
        feed_openness(16'd32768);
        feed_openness(16'd32768);
        settle_block();
        write_all(65535, VEL_MAX, 65535, 255, 255, 65535, 65535, 65535);
        feed_openness(16'd32768);
        feed_openness(16'hFFFF);
        feed_openness(16'd0);
        feed_openness(16'h7FFF);
        feed_openness(16'd40000);
        settle_block();
        write_all(6554, VEL_MIN, 16384, 0, 0, 32768, 32768, 32768);
        feed_openness(16'd0);
        feed_openness(16'd32768);
        feed_openness(16'd32768);
        settle_block();
    endtask

    task automatic test_counter_saturation();
        write_all(6554, -3277, 16384, 10, 255, 0, 0, 1638);
        feed_openness(16'd32768);
        repeat (270) feed_openness(16'd0);
        feed_openness(16'd20000);
        feed_openness(16'd20000);
        feed_openness(16'd32768);
        settle_block();
    endtask

    task automatic test_random_traffic(input int send_pct, input int stall_pct, input int beats);
        int sent;
        int next_settings;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        sent           = 0;
        next_settings  = 0;
        while (sent < beats) begin
            if (sent >= next_settings) begin
                settle_block();
                randomise_settings();
                next_settings = sent + $urandom_range(140, 80);
            end
            send_blink_burst(sent);
        end
        settle_block();
    endtask

    initial begin
        load_defaults();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_blinks();
        test_register_extremes();
        test_counter_saturation();
        test_random_traffic(0, 0, 340);
        test_random_traffic(88, 0, 340);
        test_random_traffic(0, 88, 340);
        test_random_traffic(34, 34, 340);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
